>>> rtl/dss_pkg.sv
// dss_pkg: shared types and constants for the deduplicating set store
// used by dedup_set_store_core and its port checker; no dependencies
`default_nettype none

package dss_pkg;

	localparam int CAPACITY = 16;
	localparam int KEY_W    = 32;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int FUNC_W   = 2;
	localparam int STAT_W   = 2;
	localparam int KEY_PORT_W = 32;
	localparam int CNT_PORT_W = 5;
	localparam int IDX_PORT_W = 4;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ADD     = 2'd0,
		FUNC_DISCARD = 2'd1,
		FUNC_REMOVE  = 2'd2,
		FUNC_READ    = 2'd3
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_MISSING = 2'd2,
		STAT_RANGE   = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_SCAN    = 5'b00010,
		ST_RESOLVE = 5'b00100,
		ST_SHIFT   = 5'b01000,
		ST_FINISH  = 5'b10000
	} state_t;

endpackage

`default_nettype wire

>>> rtl/dedup_set_store_core.sv
// dedup_set_store_core: bounded insertion-ordered key set with add, discard,
// remove and read-by-index; one sequencer over an entry memory with separate read and write ports
// depends on dss_pkg
//
// channel   direction  handshake                   payload
// request   in         start, accepted when !busy  func, key, index
// result    out        done, one-cycle strobe      status, found, item_key, member_count
//
// read: the request goes straight to the finish state, which registers the result and strobe
// add/discard/remove: the scan compares one entry a cycle, in the cycle after its read;
// it stops at a hit or after the last entry (an empty store skips it), then resolves and
// finishes; on a delete hit the later entries first shift down one a cycle
// reset clears the member count and control state but not the entry memory; entries are written before they are read
// no stall on the result side: done is shown for one cycle and busy drops with it
`default_nettype none

module dedup_set_store_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [dss_pkg::FUNC_W-1:0]        func,
	input  wire logic [dss_pkg::KEY_PORT_W-1:0]    key,
	input  wire logic [dss_pkg::IDX_PORT_W-1:0]    index,
	output logic                                   done,
	output logic [dss_pkg::STAT_W-1:0]             status,
	output logic                                   found,
	output logic [dss_pkg::KEY_PORT_W-1:0]         item_key,
	output logic [dss_pkg::CNT_PORT_W-1:0]         member_count
);

	localparam int KEY_W = dss_pkg::KEY_W;
	localparam int IDX_W = dss_pkg::IDX_W;
	localparam int CNT_W = dss_pkg::CNT_W;

	dss_pkg::state_t  state_q;
	dss_pkg::func_t   func_q;
	dss_pkg::status_t stat_q;
	logic [KEY_W-1:0] key_q;
	logic             hit_q;
	logic [IDX_W-1:0] pos_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] ptr_q;
	logic [CNT_W-1:0] sh_q;
	logic             cmp_vld_s1;
	logic [IDX_W-1:0] cmp_idx_s1;
	logic             wr_vld_s1;
	logic [IDX_W-1:0] wr_addr_s1;

	logic                          done_q;
	dss_pkg::status_t              out_stat_q;
	logic                          out_found_q;
	logic [dss_pkg::KEY_PORT_W-1:0] out_key_q;
	logic [dss_pkg::CNT_PORT_W-1:0] out_cnt_q;

	logic [KEY_W-1:0] mem_q [dss_pkg::CAPACITY];
	logic [KEY_W-1:0] rd_data_q;

	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [KEY_W-1:0] wr_data;
	logic [IDX_W-1:0] rd_addr;
	logic             issue;
	logic             hit;
	logic             last;
	logic [CNT_W-1:0] sh_nxt;
	logic             full;
	logic             add_wr;
	logic             idx_ok;

	assign issue  = ptr_q < count_q;
	assign hit    = cmp_vld_s1 && (rd_data_q == key_q);
	assign last   = cmp_vld_s1 && ({1'b0, cmp_idx_s1} == (count_q - CNT_W'(1)));
	assign sh_nxt = sh_q + CNT_W'(1);
	assign full   = count_q == CNT_W'(dss_pkg::CAPACITY);
	assign idx_ok = CNT_W'(index) < count_q;
	assign add_wr = (state_q == dss_pkg::ST_RESOLVE) && (func_q == dss_pkg::FUNC_ADD)
		&& !hit_q && !full;

	always_comb begin
		rd_addr = ptr_q[IDX_W-1:0];
		case (state_q)
			dss_pkg::ST_IDLE:  rd_addr = IDX_W'(index);
			dss_pkg::ST_SCAN:  rd_addr = ptr_q[IDX_W-1:0];
			dss_pkg::ST_SHIFT: rd_addr = sh_nxt[IDX_W-1:0];
			default:           rd_addr = ptr_q[IDX_W-1:0];
		endcase
	end

	// shifted entries and appended keys share the single write port
	always_comb begin
		wr_en   = wr_vld_s1 || add_wr;
		wr_addr = wr_vld_s1 ? wr_addr_s1 : count_q[IDX_W-1:0];
		wr_data = wr_vld_s1 ? rd_data_q : key_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dss_pkg::ST_IDLE;
			func_q      <= dss_pkg::FUNC_ADD;
			stat_q      <= dss_pkg::STAT_OK;
			key_q       <= '0;
			hit_q       <= 1'b0;
			pos_q       <= '0;
			count_q     <= '0;
			ptr_q       <= '0;
			sh_q        <= '0;
			cmp_vld_s1  <= 1'b0;
			cmp_idx_s1  <= '0;
			wr_vld_s1   <= 1'b0;
			wr_addr_s1  <= '0;
			done_q      <= 1'b0;
			out_stat_q  <= dss_pkg::STAT_OK;
			out_found_q <= 1'b0;
			out_key_q   <= '0;
			out_cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				dss_pkg::ST_IDLE: begin
					cmp_vld_s1 <= 1'b0;
					wr_vld_s1  <= 1'b0;
					if (start) begin
						func_q <= dss_pkg::func_t'(func);
						key_q  <= KEY_W'(key);
						hit_q  <= 1'b0;
						ptr_q  <= '0;
						stat_q <= dss_pkg::STAT_OK;
						if (dss_pkg::func_t'(func) == dss_pkg::FUNC_READ) begin
							if (!idx_ok) begin
								stat_q <= dss_pkg::STAT_RANGE;
							end
							state_q <= dss_pkg::ST_FINISH;
						end else if (count_q == '0) begin
							state_q <= dss_pkg::ST_RESOLVE;
						end else begin
							state_q <= dss_pkg::ST_SCAN;
						end
					end
				end
				dss_pkg::ST_SCAN: begin
					// the compare of each entry runs in the cycle after its read address
					ptr_q      <= ptr_q + CNT_W'(1);
					cmp_vld_s1 <= issue;
					cmp_idx_s1 <= ptr_q[IDX_W-1:0];
					if (hit) begin
						hit_q   <= 1'b1;
						pos_q   <= cmp_idx_s1;
						state_q <= dss_pkg::ST_RESOLVE;
					end else if (last) begin
						state_q <= dss_pkg::ST_RESOLVE;
					end
				end
				dss_pkg::ST_RESOLVE: begin
					cmp_vld_s1 <= 1'b0;
					state_q    <= dss_pkg::ST_FINISH;
					case (func_q)
						dss_pkg::FUNC_ADD: begin
							if (!hit_q) begin
								if (full) begin
									stat_q <= dss_pkg::STAT_FULL;
								end else begin
									count_q <= count_q + CNT_W'(1);
								end
							end
						end
						dss_pkg::FUNC_DISCARD, dss_pkg::FUNC_REMOVE: begin
							if (hit_q) begin
								sh_q      <= CNT_W'(pos_q);
								wr_vld_s1 <= 1'b0;
								state_q   <= dss_pkg::ST_SHIFT;
							end else if (func_q == dss_pkg::FUNC_REMOVE) begin
								stat_q <= dss_pkg::STAT_MISSING;
							end
						end
						default: begin
							stat_q <= stat_q;
						end
					endcase
				end
				dss_pkg::ST_SHIFT: begin
					// read entry i+1 now, write it to entry i next cycle
					if (sh_nxt < count_q) begin
						wr_vld_s1  <= 1'b1;
						wr_addr_s1 <= sh_q[IDX_W-1:0];
						sh_q       <= sh_nxt;
					end else begin
						wr_vld_s1 <= 1'b0;
						count_q   <= count_q - CNT_W'(1);
						state_q   <= dss_pkg::ST_FINISH;
					end
				end
				dss_pkg::ST_FINISH: begin
					done_q      <= 1'b1;
					out_stat_q  <= stat_q;
					out_found_q <= hit_q;
					out_key_q   <= ((func_q == dss_pkg::FUNC_READ) && (stat_q == dss_pkg::STAT_OK))
						? dss_pkg::KEY_PORT_W'(rd_data_q) : '0;
					out_cnt_q   <= dss_pkg::CNT_PORT_W'(count_q);
					state_q     <= dss_pkg::ST_IDLE;
				end
				default: begin
					state_q <= dss_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign busy         = state_q != dss_pkg::ST_IDLE;
	assign done         = done_q;
	assign status       = out_stat_q;
	assign found        = out_found_q;
	assign item_key     = out_key_q;
	assign member_count = out_cnt_q;

endmodule

`default_nettype wire

>>> rtl/dss_checker.sv
// dss_checker: port-level assertions for dedup_set_store_core, bound to it below
// depends on dss_pkg
`default_nettype none

module dss_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              start,
	input wire logic                              busy,
	input wire logic                              done,
	input wire logic [dss_pkg::STAT_W-1:0]        status,
	input wire logic                              found,
	input wire logic [dss_pkg::KEY_PORT_W-1:0]    item_key,
	input wire logic [dss_pkg::CNT_PORT_W-1:0]    member_count
);

	// an accepted request keeps the block busy until its result
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && !$past(done)))
		else $error("result strobe while busy or on consecutive cycles");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (member_count <= dss_pkg::CNT_PORT_W'(dss_pkg::CAPACITY)))
		else $error("member count beyond capacity");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == dss_pkg::STAT_FULL)) |->
		((member_count == dss_pkg::CNT_PORT_W'(dss_pkg::CAPACITY)) && !found))
		else $error("full status with room left or key found");

	// only a successful read returns a key, and a read never reports found
	a_item_key: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (item_key != '0)) |-> ((status == dss_pkg::STAT_OK) && !found))
		else $error("item key returned on a failed or non-read request");

endmodule

bind dedup_set_store_core dss_checker u_dss_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.status       (status),
	.found        (found),
	.item_key     (item_key),
	.member_count (member_count)
);

`default_nettype wire

>>> verif/testbench.sv
// testbench: self-checking bench for dedup_set_store_core
// directed and random request streams checked against an in-bench model of the key set
// depends on dss_pkg and dedup_set_store_core
module testbench;
	import dss_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_ITEMS = 750;
	localparam int PHASE_LEN    = 40;
	localparam int POOL_SIZE    = 20;

	typedef struct {
		status_t                 status;
		logic                    found;
		logic [KEY_PORT_W-1:0]   item_key;
		logic [CNT_PORT_W-1:0]   member_count;
	} set_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic [FUNC_W-1:0]       func = FUNC_ADD;
	logic [KEY_PORT_W-1:0]   key = '0;
	logic [IDX_PORT_W-1:0]   index = '0;
	logic                    busy;
	logic                    done;
	logic [STAT_W-1:0]       status;
	logic                    found;
	logic [KEY_PORT_W-1:0]   item_key;
	logic [CNT_PORT_W-1:0]   member_count;

	// in-bench copy of the set
	logic [KEY_W-1:0]        set_members [CAPACITY];
	int unsigned             set_size = 0;

	set_result_t             expected_results [$];
	set_result_t             oldest;
	logic [KEY_PORT_W-1:0]   key_pool [POOL_SIZE];
	int                      op_counts [4] = '{0, 0, 0, 0};
	int                      status_counts [4] = '{0, 0, 0, 0};
	int                      results_checked = 0;
	int                      error_count = 0;
	int                      cycle_count = 0;
	bit                      no_idle = 1'b0;

	dedup_set_store_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.key          (key),
		.index        (index),
		.done         (done),
		.status       (status),
		.found        (found),
		.item_key     (item_key),
		.member_count (member_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// applies one request to the set copy and returns what the block should answer
	function automatic set_result_t set_apply(func_t f, logic [KEY_PORT_W-1:0] k,
			logic [IDX_PORT_W-1:0] idx);
		set_result_t r;
		int pos;
		r.status   = STAT_OK;
		r.found    = 1'b0;
		r.item_key = '0;
		if (f == FUNC_READ) begin
			if (idx < set_size) r.item_key = set_members[idx];
			else r.status = STAT_RANGE;
		end else begin
			pos = -1;
			for (int i = 0; i < set_size; i++)
				if (pos < 0 && set_members[i] == k[KEY_W-1:0]) pos = i;
			r.found = (pos >= 0);
			if (f == FUNC_ADD) begin
				if (pos < 0) begin
					if (set_size < CAPACITY) begin
						set_members[set_size] = k[KEY_W-1:0];
						set_size++;
					end else begin
						r.status = STAT_FULL;
					end
				end
			end else if (pos >= 0) begin
				// close the gap, later entries move down one place
				for (int i = pos; i + 1 < set_size; i++) set_members[i] = set_members[i + 1];
				set_size--;
			end else if (f == FUNC_REMOVE) begin
				r.status = STAT_MISSING;
			end
		end
		r.member_count = set_size[CNT_PORT_W-1:0];
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		if (error_count < 100) $display("mismatch at cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	// one request; returns at the edge where it is taken, start left high
	task automatic send_req(input func_t f, input logic [KEY_PORT_W-1:0] k,
			input logic [IDX_PORT_W-1:0] idx);
		func  <= f;
		key   <= k;
		index <= idx;
		// start held low at random on about 38 percent of tries, never while no_idle is set
		do begin
			start <= no_idle || ($urandom_range(99) >= 38);
			@(posedge clk);
		end while (start !== 1'b1 || busy !== 1'b0);
		expected_results.push_back(set_apply(f, k, idx));
		op_counts[f]++;
	endtask

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (expected_results.size() == 0) begin
				flag_mismatch("result strobe with no request pending");
			end else begin
				oldest = expected_results.pop_front();
				results_checked++;
				status_counts[oldest.status]++;
				if (status !== oldest.status)
					flag_mismatch($sformatf("status %0d, want %0d", status, oldest.status));
				if (found !== oldest.found)
					flag_mismatch($sformatf("found %0b, want %0b", found, oldest.found));
				if (item_key !== oldest.item_key)
					flag_mismatch($sformatf("item_key %h, want %h", item_key, oldest.item_key));
				if (member_count !== oldest.member_count)
					flag_mismatch($sformatf("member_count %0d, want %0d",
						member_count, oldest.member_count));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_results.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic test_empty_store;
		send_req(FUNC_READ, 32'h0, 4'd0);
		send_req(FUNC_READ, 32'hFFFF_FFFF, 4'd15);
		send_req(FUNC_REMOVE, 32'h0000_1234, 4'd0);
		send_req(FUNC_DISCARD, 32'h0, 4'd0);
	endtask

	task automatic test_basic_ops;
		send_req(FUNC_ADD, 32'h0, 4'd0);
		send_req(FUNC_ADD, 32'hFFFF_FFFF, 4'd15);
		send_req(FUNC_ADD, 32'h0, 4'd0);
		send_req(FUNC_ADD, 32'hA5A5_5A5A, 4'd0);
		send_req(FUNC_READ, 32'h0, 4'd0);
		send_req(FUNC_READ, 32'h0, 4'd2);
		send_req(FUNC_READ, 32'h0, 4'd3);
		// delete from the middle, then check the shift
		send_req(FUNC_DISCARD, 32'hFFFF_FFFF, 4'd0);
		send_req(FUNC_READ, 32'h0, 4'd1);
		send_req(FUNC_REMOVE, 32'h0, 4'd0);
		send_req(FUNC_REMOVE, 32'h0, 4'd0);
		send_req(FUNC_DISCARD, 32'hA5A5_5A5A, 4'd0);
	endtask

	task automatic test_capacity;
		for (int i = 0; i < CAPACITY; i++)
			send_req(FUNC_ADD, 32'h1000_0000 + i * 32'h0101_0101, 4'(i));
		send_req(FUNC_READ, 32'h0, 4'd15);
		send_req(FUNC_ADD, 32'hDEAD_0001, 4'd0);
		send_req(FUNC_ADD, 32'h1000_0000, 4'd0);
		// first entry out: every later entry moves
		send_req(FUNC_REMOVE, 32'h1000_0000, 4'd0);
		send_req(FUNC_READ, 32'h0, 4'd14);
		send_req(FUNC_READ, 32'h0, 4'd15);
	endtask

	task automatic test_random_mix;
		func_t f;
		logic [KEY_PORT_W-1:0] k;
		int r;
		int sel;
		bit growing;
		for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom();
		growing = 1'b1;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % PHASE_LEN == 0 && n != 0) begin
				growing = ~growing;
				repeat (3) key_pool[$urandom_range(POOL_SIZE - 1)] = $urandom();
			end
			no_idle = (n >= 300 && n < 420);
			r = $urandom_range(99);
			if (growing)
				f = func_t'((r < 55) ? FUNC_ADD : (r < 65) ? FUNC_DISCARD :
					(r < 78) ? FUNC_REMOVE : FUNC_READ);
			else
				f = func_t'((r < 15) ? FUNC_ADD : (r < 45) ? FUNC_DISCARD :
					(r < 75) ? FUNC_REMOVE : FUNC_READ);
			sel = $urandom_range(99);
			if ((f == FUNC_DISCARD || f == FUNC_REMOVE) && set_size > 0 && sel < 45)
				k = set_members[$urandom_range(set_size - 1)];
			else if (sel < 88)
				k = key_pool[$urandom_range(POOL_SIZE - 1)];
			else
				k = $urandom();
			send_req(f, k, 4'($urandom_range(15)));
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_store();
		test_basic_ops();
		test_capacity();
		test_random_mix();
		start <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("requests: %0d add, %0d discard, %0d remove, %0d read; %0d results checked",
			op_counts[FUNC_ADD], op_counts[FUNC_DISCARD], op_counts[FUNC_REMOVE],
			op_counts[FUNC_READ], results_checked);
		$display("outcomes: %0d ok, %0d store full, %0d key missing, %0d index range",
			status_counts[STAT_OK], status_counts[STAT_FULL], status_counts[STAT_MISSING],
			status_counts[STAT_RANGE]);
		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", error_count);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
